// ----- rtl/sega_pkg.sv -----
// shared types, constants and helpers of the sensor exposure and gain applier
package sega_pkg;

  // fixed point formats of the requests
  localparam int GAIN_FRAC_BITS     = 18;
  localparam int EXPOSURE_FRAC_BITS = 8;
  localparam int HISTORY_DEPTH      = 4;
  localparam int HIST_AW            = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // field widths
  localparam int MODE_W      = 2;
  localparam int REQ_W       = 24;
  localparam int FRAME_W     = 15;
  localparam int DELAY_W     = 2;
  localparam int PENDING_W   = 3;
  localparam int GAIN_CODE_W = 8;
  localparam int SHUTTER_W   = 16;
  localparam int VALUE_W     = 25;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;

  // sensor limits
  localparam int GAIN_MAX_CODE = 720 / 3;
  localparam int GAIN_SCALE    = 20;
  localparam int SHORT_READOUT = 273;
  localparam int LONG_MIN      = 273 + 9;
  localparam int SHORT_MAX     = 273 - 8;
  localparam int SHORT_MIN     = 9;
  localparam int NORMAL_MIN    = 8;
  localparam int NORMAL_MARGIN = 4;
  localparam int WDR_MARGIN    = 8;
  localparam int SHORT_SHIFT   = 16;
  localparam int SHORT_SAT     = (1 << SHUTTER_W) - 1;
  localparam int FRAME_RESET   = 2256;

  // result queue
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW        = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_STALL_LVL = FIFO_DEPTH - 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_GAIN     = 2'd0,
    MODE_EXPOSURE = 2'd1,
    MODE_TICK     = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WDR_MODE       = 2'd0,
    CFG_FRAME_LINES    = 2'd1,
    CFG_GAIN_DELAY     = 2'd2,
    CFG_EXPOSURE_DELAY = 2'd3
  } cfg_idx_t;

  localparam logic KIND_GAIN     = 1'b0;
  localparam logic KIND_EXPOSURE = 1'b1;

  typedef struct packed {
    logic               wdr_mode;
    logic [FRAME_W-1:0] frame_lines;
    logic [DELAY_W-1:0] gain_delay;
    logic [DELAY_W-1:0] exposure_delay;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  gain_log;
    logic [REQ_W-1:0]  exposure_long;
    logic [REQ_W-1:0]  exposure_short;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

  // up to two words per tick, packed from r0
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // history slot for a delay, the oldest one beyond the depth
  function automatic logic [HIST_AW-1:0] hist_idx(input logic [DELAY_W-1:0] d);
    logic [HIST_AW+DELAY_W-1:0] wide;
    wide = (HIST_AW + DELAY_W)'(d);
    if (32'(d) < HISTORY_DEPTH) begin
      return wide[HIST_AW-1:0];
    end
    return HIST_AW'(HISTORY_DEPTH - 1);
  endfunction

endpackage

// ----- rtl/sega_calc.sv -----
// gain code and shutter value computation for one request
module sega_calc
  import sega_pkg::*;
(
  input  cfg_t                   cfg,
  input  logic [REQ_W-1:0]       gain_log,
  input  logic [REQ_W-1:0]       exposure_long,
  input  logic [REQ_W-1:0]       exposure_short,
  output logic [GAIN_CODE_W-1:0] gain_code,
  output logic [SHUTTER_W-1:0]   long_val,
  output logic [SHUTTER_W-1:0]   short_val
);

  localparam int PROD_W = REQ_W + 5;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] g_full;
  logic [REQ_W-1:0]  el;
  logic [REQ_W-1:0]  es;
  logic [REQ_W-1:0]  frame_w;
  logic [REQ_W-1:0]  two_f;
  logic [REQ_W-1:0]  n_elc;
  logic [REQ_W-1:0]  n_lv;
  logic [REQ_W-1:0]  n_hi;
  logic [REQ_W-1:0]  n_lv_hi;
  logic [REQ_W-1:0]  n_lv_fin;
  logic [REQ_W-1:0]  n_sv;
  logic [REQ_W-1:0]  w_lv;
  logic [REQ_W-1:0]  w_hi;
  logic [REQ_W-1:0]  w_lv_hi;
  logic [REQ_W-1:0]  w_lv_fin;
  logic [REQ_W-1:0]  w_sv;
  logic [REQ_W-1:0]  w_sv_lo;
  logic [REQ_W-1:0]  w_sv_fin;

  // gain: scale by 20, drop the fraction, clamp to the top code
  assign prod   = PROD_W'(gain_log) * PROD_W'(GAIN_SCALE);
  assign g_full = prod >> GAIN_FRAC_BITS;
  assign gain_code = (g_full > PROD_W'(GAIN_MAX_CODE)) ? GAIN_CODE_W'(GAIN_MAX_CODE)
                                                       : g_full[GAIN_CODE_W-1:0];

  // integer lines of the exposure requests
  assign el      = exposure_long >> EXPOSURE_FRAC_BITS;
  assign es      = exposure_short >> EXPOSURE_FRAC_BITS;
  assign frame_w = REQ_W'(cfg.frame_lines);
  assign two_f   = REQ_W'({cfg.frame_lines, 1'b0});

  // normal mode: frame minus exposure, clamped to 8..frame-4
  assign n_elc    = (el > frame_w) ? frame_w : el;
  assign n_lv     = frame_w - n_elc;
  assign n_hi     = (frame_w > REQ_W'(NORMAL_MARGIN)) ? frame_w - REQ_W'(NORMAL_MARGIN) : '0;
  assign n_lv_hi  = (n_lv > n_hi) ? n_hi : n_lv;
  assign n_lv_fin = (n_lv_hi < REQ_W'(NORMAL_MIN)) ? REQ_W'(NORMAL_MIN) : n_lv_hi;
  assign n_sv     = (es > REQ_W'(SHORT_SAT)) ? REQ_W'(SHORT_SAT) : es;

  // wdr long: 2*frame minus exposure, saturating, clamped to 282..2*frame-8
  assign w_lv     = (two_f > el) ? two_f - el : '0;
  assign w_hi     = (two_f > REQ_W'(WDR_MARGIN)) ? two_f - REQ_W'(WDR_MARGIN) : '0;
  assign w_lv_hi  = (w_lv > w_hi) ? w_hi : w_lv;
  assign w_lv_fin = (w_lv_hi < REQ_W'(LONG_MIN)) ? REQ_W'(LONG_MIN) : w_lv_hi;

  // wdr short: 273 minus exposure, saturating, clamped to 9..265
  assign w_sv     = (REQ_W'(SHORT_READOUT) > es) ? REQ_W'(SHORT_READOUT) - es : '0;
  assign w_sv_lo  = (w_sv < REQ_W'(SHORT_MIN)) ? REQ_W'(SHORT_MIN) : w_sv;
  assign w_sv_fin = (w_sv_lo > REQ_W'(SHORT_MAX)) ? REQ_W'(SHORT_MAX) : w_sv_lo;

  // mode select
  assign long_val  = cfg.wdr_mode ? w_lv_fin[SHUTTER_W-1:0] : n_lv_fin[SHUTTER_W-1:0];
  assign short_val = cfg.wdr_mode ? w_sv_fin[SHUTTER_W-1:0] : n_sv[SHUTTER_W-1:0];

endmodule

// ----- rtl/sega_hist.sv -----
// value histories, pending counters and tick write generation
module sega_hist
  import sega_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   item_valid,
  input  logic [MODE_W-1:0]      mode,
  input  logic [GAIN_CODE_W-1:0] gain_code,
  input  logic [SHUTTER_W-1:0]   long_val,
  input  logic [SHUTTER_W-1:0]   short_val,
  output push_t                  push
);

  logic [GAIN_CODE_W-1:0] gain_hist_r  [HISTORY_DEPTH];
  logic [SHUTTER_W-1:0]   long_hist_r  [HISTORY_DEPTH];
  logic [SHUTTER_W-1:0]   short_hist_r [HISTORY_DEPTH];
  logic [PENDING_W-1:0]   gain_pending_r;
  logic [PENDING_W-1:0]   exp_pending_r;
  logic [PENDING_W-1:0]   gain_pending_nxt;
  logic [PENDING_W-1:0]   exp_pending_nxt;

  logic                   is_gain;
  logic                   is_exp;
  logic                   is_tick;
  logic                   gain_change;
  logic                   exp_change;
  logic                   gain_go;
  logic                   exp_go;
  logic [HIST_AW-1:0]     gi;
  logic [HIST_AW-1:0]     ei;
  result_t                gain_word;
  result_t                exp_word;
  logic [VALUE_W-1:0]     exp_value;

  // decode the item
  always_comb begin
    is_gain = 1'b0;
    is_exp  = 1'b0;
    is_tick = 1'b0;
    case (mode)
      MODE_GAIN:     is_gain = item_valid;
      MODE_EXPOSURE: is_exp  = item_valid;
      MODE_TICK:     is_tick = item_valid;
      default:       ;
    endcase
  end

  assign gain_change = is_gain && (gain_hist_r[0] != gain_code);
  assign exp_change  = is_exp && ((long_hist_r[0] != long_val) || (short_hist_r[0] != short_val));
  assign gain_go     = is_tick && (gain_pending_r != '0);
  assign exp_go      = is_tick && (exp_pending_r != '0);

  // pending counters
  always_comb begin
    gain_pending_nxt = gain_pending_r;
    exp_pending_nxt  = exp_pending_r;
    if (gain_change) begin
      gain_pending_nxt = PENDING_W'(cfg.gain_delay) + PENDING_W'(1);
    end else if (gain_go) begin
      gain_pending_nxt = gain_pending_r - PENDING_W'(1);
    end
    if (exp_change) begin
      exp_pending_nxt = PENDING_W'(cfg.exposure_delay) + PENDING_W'(1);
    end else if (exp_go) begin
      exp_pending_nxt = exp_pending_r - PENDING_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_pending_r <= '0;
      exp_pending_r  <= '0;
    end else begin
      gain_pending_r <= gain_pending_nxt;
      exp_pending_r  <= exp_pending_nxt;
    end
  end

  // newest entry takes a changed value, a tick shifts towards older
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        gain_hist_r[i]  <= '0;
        long_hist_r[i]  <= '0;
        short_hist_r[i] <= '0;
      end
    end else begin
      if (gain_change) begin
        gain_hist_r[0] <= gain_code;
      end
      if (exp_change) begin
        long_hist_r[0]  <= long_val;
        short_hist_r[0] <= short_val;
      end
      if (is_tick) begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
          gain_hist_r[i]  <= gain_hist_r[i-1];
          long_hist_r[i]  <= long_hist_r[i-1];
          short_hist_r[i] <= short_hist_r[i-1];
        end
      end
    end
  end

  // words of this tick, gain before exposure
  assign gi        = hist_idx(cfg.gain_delay);
  assign ei        = hist_idx(cfg.exposure_delay);
  assign exp_value = cfg.wdr_mode ? VALUE_W'({short_hist_r[ei], long_hist_r[ei]})
                                  : VALUE_W'(long_hist_r[ei]);

  always_comb begin
    gain_word.kind  = KIND_GAIN;
    gain_word.value = VALUE_W'(gain_hist_r[gi]);
    gain_word.last  = !exp_go;
    exp_word.kind   = KIND_EXPOSURE;
    exp_word.value  = exp_value;
    exp_word.last   = 1'b1;
    push.cnt = {1'b0, gain_go} + {1'b0, exp_go};
    push.r0  = gain_go ? gain_word : exp_word;
    push.r1  = exp_word;
  end

`ifndef NO_ASSERTIONS
  // a counter never runs above the longest delay plus one
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (gain_pending_r <= PENDING_W'(4)) && (exp_pending_r <= PENDING_W'(4)))
    else $error("pending counter out of range");

  // a two-word tick is gain then exposure, marked last only on the second
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> ((push.r0.kind == KIND_GAIN) && !push.r0.last &&
                            (push.r1.kind == KIND_EXPOSURE) && push.r1.last))
    else $error("tick word pair malformed");
`endif

endmodule

// ----- rtl/sega_fifo.sv -----
// result queue taking up to two words a cycle and giving one
module sega_fifo
  import sega_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output logic    not_empty,
  output logic    almost_full,
  output result_t head
);

  result_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r;
  logic [FIFO_AW-1:0]   wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_nxt;
  logic                 do_pop;

  assign not_empty   = (count_r != '0);
  assign almost_full = (count_r >= FIFO_CW'(FIFO_STALL_LVL));
  assign head        = mem_r[rd_ptr_r];
  assign do_pop      = pop && not_empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(do_pop);
    count_nxt  = count_r + FIFO_CW'(push.cnt) - FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.r1;
    end
  end

`ifndef NO_ASSERTIONS
  // the input stall level leaves room for every word in flight
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(count_r) + 32'(push.cnt)) <= (FIFO_DEPTH + 32'(do_pop)))
    else $error("result queue overflow");

  // pointers and fill count agree
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    FIFO_AW'(wr_ptr_r - rd_ptr_r) == count_r[FIFO_AW-1:0])
    else $error("result queue pointers disagree with count");

  // a stalled head word stays put
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (not_empty && !pop) |=> $stable(head))
    else $error("head word changed while stalled");
`endif

endmodule

// ----- rtl/sensor_exposure_gain_applier_core.sv -----
// top level of the sensor exposure and gain applier
//
// Usage: the in_ channel carries auto-exposure requests and frame ticks
// (in_mode 0 gain, 1 exposure, 2 tick; 3 is ignored). Requests only update
// the internal histories; a tick emits the pending gain write, then the
// pending exposure write, on the out_ channel, with out_last on the final
// word of that tick. A tick with nothing pending gives no word.
// A word moves on a channel at a rising edge with valid high and stall low.
// The cfg_ channel writes wdr_mode, frame_lines, gain_delay and
// exposure_delay (index 0..3); cfg_ready is always high and writes belong
// while the block is idle.
// Flow: an item is registered on acceptance and processed in the next
// cycle; its words are then written into the result queue. One item per
// cycle is accepted while in_stall is low; words leave at one per cycle,
// while out_stall is low, through an eight-word result queue, and
// in_stall rises when four or more words wait there.
// Reset (rst_n low, synchronous) clears histories, pending counters, the
// queue and loads the register defaults. A stalling receiver only fills the
// queue; nothing is lost.
module sensor_exposure_gain_applier_core
  import sega_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [REQ_W-1:0]      in_gain_log,
  input  logic [REQ_W-1:0]      in_exposure_long,
  input  logic [REQ_W-1:0]      in_exposure_short,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_write_kind,
  output logic [VALUE_W-1:0]    out_write_value,
  output logic                  out_last
);

  cfg_t                   cfg_r;
  cfg_t                   cfg_nxt;
  item_t                  item_r;
  logic                   item_valid_r;
  logic                   item_valid_nxt;
  logic                   in_accept;
  logic                   almost_full;
  logic [GAIN_CODE_W-1:0] gain_code;
  logic [SHUTTER_W-1:0]   long_val;
  logic [SHUTTER_W-1:0]   short_val;
  push_t                  push;
  result_t                head;

  // register writes
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_WDR_MODE:       cfg_nxt.wdr_mode       = cfg_data[0];
        CFG_FRAME_LINES:    cfg_nxt.frame_lines    = cfg_data[FRAME_W-1:0];
        CFG_GAIN_DELAY:     cfg_nxt.gain_delay     = cfg_data[DELAY_W-1:0];
        CFG_EXPOSURE_DELAY: cfg_nxt.exposure_delay = cfg_data[DELAY_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wdr_mode       <= 1'b0;
      cfg_r.frame_lines    <= FRAME_W'(FRAME_RESET);
      cfg_r.gain_delay     <= '0;
      cfg_r.exposure_delay <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register
  assign in_stall       = almost_full;
  assign in_accept      = in_valid && !in_stall;
  assign item_valid_nxt = in_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.mode           <= in_mode;
      item_r.gain_log       <= in_gain_log;
      item_r.exposure_long  <= in_exposure_long;
      item_r.exposure_short <= in_exposure_short;
    end
  end

  // value computation
  sega_calc u_calc (
    .cfg            (cfg_r),
    .gain_log       (item_r.gain_log),
    .exposure_long  (item_r.exposure_long),
    .exposure_short (item_r.exposure_short),
    .gain_code      (gain_code),
    .long_val       (long_val),
    .short_val      (short_val)
  );

  // histories and tick words
  sega_hist u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid_r),
    .mode       (item_r.mode),
    .gain_code  (gain_code),
    .long_val   (long_val),
    .short_val  (short_val),
    .push       (push)
  );

  // result queue
  sega_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .pop         (!out_stall),
    .not_empty   (out_valid),
    .almost_full (almost_full),
    .head        (head)
  );

  assign out_write_kind  = head.kind;
  assign out_write_value = head.value;
  assign out_last        = head.last;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the sensor exposure and gain applier core
module testbench;
  import sega_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE          = 8;
  localparam int DRAIN_GUARD     = 20000;

  // shadow of the register file and histories, plus the writes still owed
  class shutter_gain_scoreboard;
    logic                   wdr;
    logic [FRAME_W-1:0]     frame;
    logic [DELAY_W-1:0]     gain_dly;
    logic [DELAY_W-1:0]     exp_dly;
    logic [GAIN_CODE_W-1:0] gain_hist [HISTORY_DEPTH];
    logic [SHUTTER_W-1:0]   long_hist [HISTORY_DEPTH];
    logic [SHUTTER_W-1:0]   short_hist [HISTORY_DEPTH];
    logic [PENDING_W-1:0]   gain_pend;
    logic [PENDING_W-1:0]   exp_pend;
    result_t                due_writes [$];
    int                     errors;

    function new();
      wdr = 1'b0;
      frame = FRAME_W'(FRAME_RESET);
      gain_dly = '0;
      exp_dly = '0;
      gain_pend = '0;
      exp_pend = '0;
      errors = 0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        gain_hist[i] = '0;
        long_hist[i] = '0;
        short_hist[i] = '0;
      end
    endfunction

    function logic [31:0] floor_sub(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : 32'd0;
    endfunction

    // delays past the history read the oldest entry
    function int slot(logic [DELAY_W-1:0] d);
      return (int'(d) < HISTORY_DEPTH) ? int'(d) : HISTORY_DEPTH - 1;
    endfunction

    function int waiting();
      return due_writes.size();
    endfunction

    // register values are cut to the register width
    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WDR_MODE:       wdr = data[0];
        CFG_FRAME_LINES:    frame = data[FRAME_W-1:0];
        CFG_GAIN_DELAY:     gain_dly = data[DELAY_W-1:0];
        CFG_EXPOSURE_DELAY: exp_dly = data[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(item_t it);
      logic [31:0] g;
      logic [31:0] el;
      logic [31:0] es;
      logic [31:0] lv;
      logic [31:0] sv;
      logic [31:0] hi;
      logic [31:0] v;
      result_t     w [$];
      result_t     r;
      int          s;
      case (it.mode)
        // gain code: scale, drop the fraction, clamp
        MODE_GAIN: begin
          g = (32'(it.gain_log) * GAIN_SCALE) >> GAIN_FRAC_BITS;
          if (g > GAIN_MAX_CODE) g = GAIN_MAX_CODE;
          if (gain_hist[0] != g[GAIN_CODE_W-1:0]) begin
            gain_pend = PENDING_W'(gain_dly) + 1'b1;
            gain_hist[0] = g[GAIN_CODE_W-1:0];
          end
        end
        // shutter values, saturating subtractions in both modes
        MODE_EXPOSURE: begin
          el = 32'(it.exposure_long) >> EXPOSURE_FRAC_BITS;
          es = 32'(it.exposure_short) >> EXPOSURE_FRAC_BITS;
          if (!wdr) begin
            if (el > frame) el = 32'(frame);
            lv = 32'(frame) - el;
            hi = floor_sub(32'(frame), NORMAL_MARGIN);
            if (lv > hi) lv = hi;
            if (lv < NORMAL_MIN) lv = NORMAL_MIN;
            sv = (es > SHORT_SAT) ? SHORT_SAT : es;
          end else begin
            sv = floor_sub(SHORT_READOUT, es);
            if (sv < SHORT_MIN) sv = SHORT_MIN;
            if (sv > SHORT_MAX) sv = SHORT_MAX;
            lv = floor_sub(2 * 32'(frame), el);
            hi = floor_sub(2 * 32'(frame), WDR_MARGIN);
            if (lv > hi) lv = hi;
            if (lv < LONG_MIN) lv = LONG_MIN;
          end
          if (long_hist[0] != lv[SHUTTER_W-1:0] || short_hist[0] != sv[SHUTTER_W-1:0]) begin
            exp_pend = PENDING_W'(exp_dly) + 1'b1;
            long_hist[0] = lv[SHUTTER_W-1:0];
            short_hist[0] = sv[SHUTTER_W-1:0];
          end
        end
        // frame tick: gain first, then exposure, then age the histories
        MODE_TICK: begin
          if (gain_pend != 0) begin
            gain_pend = gain_pend - 1'b1;
            r.kind = KIND_GAIN;
            r.value = VALUE_W'(gain_hist[slot(gain_dly)]);
            r.last = 1'b0;
            w.push_back(r);
          end
          if (exp_pend != 0) begin
            s = slot(exp_dly);
            exp_pend = exp_pend - 1'b1;
            v = 32'(long_hist[s]);
            if (wdr) v = (32'(short_hist[s]) << SHORT_SHIFT) | v;
            r.kind = KIND_EXPOSURE;
            r.value = v[VALUE_W-1:0];
            r.last = 1'b0;
            w.push_back(r);
          end
          if (w.size() > 0) begin
            r = w.pop_back();
            r.last = 1'b1;
            w.push_back(r);
          end
          foreach (w[k]) due_writes.push_back(w[k]);
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            gain_hist[i] = gain_hist[i-1];
            long_hist[i] = long_hist[i-1];
            short_hist[i] = short_hist[i-1];
          end
        end
        default: ;
      endcase
    endfunction

    function void check_write(logic kind, logic [VALUE_W-1:0] value, logic last);
      result_t want;
      if (due_writes.size() == 0) begin
        $error("unexpected word: write_kind %0d write_value 0x%0h last %0d", kind, value, last);
        errors++;
        return;
      end
      want = due_writes.pop_front();
      if (kind !== want.kind) begin
        $error("write_kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (value !== want.value) begin
        $error("write_value: expected 0x%0h, actual 0x%0h", want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [MODE_W-1:0]  in_mode = '0;
  logic [REQ_W-1:0]   in_gain_log = '0;
  logic [REQ_W-1:0]   in_exposure_long = '0;
  logic [REQ_W-1:0]   in_exposure_short = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_write_kind;
  logic [VALUE_W-1:0] out_write_value;
  logic               out_last;

  shutter_gain_scoreboard sb;
  int                     tx_gap_max = 0;
  int                     rx_gap_max = 0;
  int unsigned            rx_wait = 0;
  int unsigned            hold_left = 0;
  bit                     took = 1'b0;
  bit                     hold_req = 1'b0;
  logic [REQ_W-1:0]       last_gain = '0;
  logic [REQ_W-1:0]       last_el = '0;
  logic [REQ_W-1:0]       last_es = '0;

  sensor_exposure_gain_applier_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_gain_log       (in_gain_log),
    .in_exposure_long  (in_exposure_long),
    .in_exposure_short (in_exposure_short),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_kind    (out_write_kind),
    .out_write_value   (out_write_value),
    .out_last          (out_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // safety net against a hung handshake
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // check every word taken on the result channel
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_write(out_write_kind, out_write_value, out_last);
      took = 1'b1;
    end
  end

  // receiver stalls: a random wait after each word, or a long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (took) begin
      rx_wait = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
      took = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic item_t make_item(logic [MODE_W-1:0] mode, logic [REQ_W-1:0] g,
                                      logic [REQ_W-1:0] el, logic [REQ_W-1:0] es);
    item_t it;
    it.mode = mode;
    it.gain_log = g;
    it.exposure_long = el;
    it.exposure_short = es;
    return it;
  endfunction

  // mostly well-formed requests and ticks, some repeats, some full-range noise
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it = make_item(MODE_TICK, REQ_W'($urandom), REQ_W'($urandom), REQ_W'($urandom));
    if (pick < 4) begin
      it.mode = MODE_UNUSED;
    end else if (pick < 32) begin
      it.mode = MODE_GAIN;
      case ($urandom_range(0, 7))
        0, 1: ;
        2: it.gain_log = last_gain;
        default: it.gain_log = REQ_W'($urandom_range(0, 3200000));
      endcase
      last_gain = it.gain_log;
    end else if (pick < 60) begin
      it.mode = MODE_EXPOSURE;
      case ($urandom_range(0, 7))
        0: ;
        1: begin
          it.exposure_long = last_el;
          it.exposure_short = last_es;
        end
        default: begin
          it.exposure_long = REQ_W'($urandom_range(0,
                               (2 * int'(sb.frame) + 300) << EXPOSURE_FRAC_BITS));
          it.exposure_short = REQ_W'($urandom_range(0, 300 << EXPOSURE_FRAC_BITS));
        end
      endcase
      last_el = it.exposure_long;
      last_es = it.exposure_short;
    end
    return it;
  endfunction

  // offer one item after a random gap, hold it until taken
  task automatic drive_item(input item_t it);
    int unsigned gap;
    @(negedge clk);
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_gain_log <= it.gain_log;
    in_exposure_long <= it.exposure_long;
    in_exposure_short <= it.exposure_short;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(it);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
  endtask

  // all four registers, junk in the unused upper data bits
  task automatic configure(input logic wdr, input logic [FRAME_W-1:0] frame,
                           input logic [DELAY_W-1:0] gd, input logic [DELAY_W-1:0] ed);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(CFG_WDR_MODE, {noise[13:0], wdr});
    write_reg(CFG_FRAME_LINES, frame);
    write_reg(CFG_GAIN_DELAY, {noise[27:15], gd});
    write_reg(CFG_EXPOSURE_DELAY, {noise[12:0], ed});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every owed word, then idle with no requests so the pipeline clears
  task automatic quiesce();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.waiting() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (sb.waiting() != 0) begin
      $error("%0d expected words never arrived", sb.waiting());
      sb.errors++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    item_t it;
    int    count;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: normal mode at reset values
    tx_gap_max = 3;
    rx_gap_max = 3;
    configure(1'b0, FRAME_W'(FRAME_RESET), 2'd0, 2'd0);
    drive_item(make_item(MODE_TICK, '0, '0, '0));
    drive_item(make_item(MODE_UNUSED, '1, '1, '1));
    drive_item(make_item(MODE_GAIN, 24'hFFFFFF, '0, '0));
    drive_item(make_item(MODE_TICK, '1, '1, '1));
    drive_item(make_item(MODE_GAIN, 24'h000000, '1, '1));
    drive_item(make_item(MODE_GAIN, 24'h000000, '0, '0));
    drive_item(make_item(MODE_EXPOSURE, '0, 24'h000000, 24'hFFFFFF));
    drive_item(make_item(MODE_TICK, '0, '0, '0));
    drive_item(make_item(MODE_EXPOSURE, '1, 24'hFFFFFF, 24'h000000));
    drive_item(make_item(MODE_GAIN, 24'd3145728, '0, '0));
    drive_item(make_item(MODE_TICK, '0, '0, '0));
    drive_item(make_item(MODE_TICK, '0, '0, '0));
    quiesce();

    // directed: wdr with a tiny frame, long delays reading old normal-mode history
    configure(1'b1, 15'd2, 2'd3, 2'd3);
    drive_item(make_item(MODE_EXPOSURE, '0, 24'h000000, 24'h000000));
    drive_item(make_item(MODE_EXPOSURE, '0, 24'hFFFFFF, 24'hFFFFFF));
    drive_item(make_item(MODE_GAIN, 24'd1000000, '0, '0));
    repeat (5) drive_item(make_item(MODE_TICK, '0, '0, '0));
    quiesce();

    // directed: wdr at the largest frame
    configure(1'b1, 15'h7FFF, 2'd1, 2'd2);
    drive_item(make_item(MODE_EXPOSURE, '0, 24'h000000, 24'h002300));
    repeat (3) drive_item(make_item(MODE_TICK, '0, '0, '0));
    quiesce();

    // random phases over a spread of settings and idling patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_gap_max = 15;
      rx_gap_max = 15;
      case (p)
        0: configure(1'b0, FRAME_W'(FRAME_RESET), 2'd0, 2'd0);
        1: configure(1'b1, 15'd148, 2'd3, 2'd3);
        2: begin
          configure(1'b0, 15'h7FFF, 2'd1, 2'd2);
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        3: begin
          configure(1'b1, 15'h7FFF, 2'd2, 2'd0);
          rx_gap_max = 0;
        end
        4: begin
          configure(1'b0, 15'd148, 2'd3, 2'd1);
          tx_gap_max = 0;
        end
        5: configure(1'b1, 15'd1125, 2'd0, 2'd3);
        6: configure(1'($urandom_range(0, 1)), FRAME_W'($urandom_range(148, 32767)),
                     DELAY_W'($urandom_range(0, 3)), DELAY_W'($urandom_range(0, 3)));
        default: configure(1'b0, 15'd3, 2'd2, 2'd2);
      endcase
      // receiver holds off while the sender keeps pushing
      if (p == 1 || p == 5) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        it = random_item();
        drive_item(it);
        if (it.mode != MODE_UNUSED) count++;
      end
      quiesce();
    end

    if (sb.errors == 0 && sb.waiting() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sega_pkg.sv
rtl/sega_calc.sv
rtl/sega_hist.sv
rtl/sega_fifo.sv
rtl/sensor_exposure_gain_applier_core.sv
dv/testbench.sv
